// ===== hdl/prt_pkg.sv =====
// Shared types and constants for the prefix route table.
// No dependencies; every other file but prt_ram imports this package.
package prt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int MAX_PATHS   = 4;
    localparam int PORT_COUNT  = 16;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PC_W  = $clog2(MAX_PATHS + 1);
    localparam int PI_W  = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

    typedef enum logic [2:0] {
        REQ_INSERT    = 3'd0,
        REQ_MERGE     = 3'd1,
        REQ_DELETE    = 3'd2,
        REQ_PURGE     = 3'd3,
        REQ_LOOKUP    = 3'd4,
        REQ_PURGE_ALL = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_FOUND  = 2'd1,
        STAT_TABLE_FULL = 2'd2,
        STAT_PATH_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0]                  prefix;
        logic [31:0]                  mask;
        logic                         stat;
        logic [PC_W-1:0]              pcount;
        logic [MAX_PATHS-1:0][31:0]   gw;
        logic [MAX_PATHS-1:0][3:0]    port;
    } route_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== hdl/prt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/prt_ctrl.sv =====
// Request sequencer: accept, table scan, result hand-off.
// Depends on prt_pkg.
module prt_ctrl
    import prt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = (m_valid_reg && !m_ready);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/prt_datapath.sv =====
// Route storage, scan/compaction/shift logic and result register.
// Depends on prt_pkg and prt_ram.
module prt_datapath
    import prt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_addr,
    input  logic [31:0] s_mask,
    input  logic [31:0] s_next_hop,
    input  logic [3:0]  s_port_index,
    input  logic        s_static_flag,
    output logic [1:0]  m_status,
    output logic        m_hit,
    output logic [31:0] m_out_gateway,
    output logic [3:0]  m_out_port
);

    logic [2:0]       req_reg, req_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      mask_reg, mask_next;
    logic [31:0]      gw_reg, gw_next;
    logic [3:0]       port_reg, port_next;
    logic             st_reg, st_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] pidx_reg, pidx_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             shift_reg, shift_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] sel_idx_reg, sel_idx_next;
    route_t           sel_rec_reg, sel_rec_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [31:0]      lk_gw_reg, lk_gw_next;
    logic [3:0]       lk_port_reg, lk_port_next;
    logic [1:0]       status_reg, status_next;
    logic             hit_reg, hit_next;
    logic [31:0]      ogw_reg, ogw_next;
    logic [3:0]       oport_reg, oport_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    route_t           wdata;
    route_t           e;
    route_t           rec;

    logic [31:0] amask;
    logic        port_ok, room, keymatch, repl_m, del_m, lk_m, greater;
    logic        start_shift, drop;

    prt_ram #(
        .WIDTH ($bits(route_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (e)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        addr_reg    <= addr_next;
        mask_reg    <= mask_next;
        gw_reg      <= gw_next;
        port_reg    <= port_next;
        st_reg      <= st_next;
        rd_idx_reg  <= rd_idx_next;
        pidx_reg    <= pidx_next;
        found_reg   <= found_next;
        shift_reg   <= shift_next;
        pos_reg     <= pos_next;
        sel_idx_reg <= sel_idx_next;
        sel_rec_reg <= sel_rec_next;
        j_reg       <= j_next;
        lk_gw_reg   <= lk_gw_next;
        lk_port_reg <= lk_port_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        ogw_reg     <= ogw_next;
        oport_reg   <= oport_next;
    end

    assign amask    = addr_reg & mask_reg;
    assign port_ok  = (32'(port_reg) < PORT_COUNT);
    assign room     = (count_reg < CNT_W'(TABLE_DEPTH));
    assign keymatch = (e.mask == mask_reg) && ((e.prefix & mask_reg) == amask);
    assign repl_m   = keymatch && (e.stat == st_reg);
    assign del_m    = ((e.prefix & e.mask) == amask) && (e.stat == st_reg);
    assign lk_m     = ((e.prefix & e.mask) == (addr_reg & e.mask));
    assign greater  = (mask_reg > e.mask) ||
                      ((mask_reg == e.mask) && (amask > (e.prefix & e.mask)));

    assign stat.scan_done = (rd_idx_reg >= count_reg) && !pend_reg;

    always_comb begin
        req_next     = req_reg;
        addr_next    = addr_reg;
        mask_next    = mask_reg;
        gw_next      = gw_reg;
        port_next    = port_reg;
        st_next      = st_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        pidx_next    = pidx_reg;
        pend_next    = pend_reg;
        found_next   = found_reg;
        shift_next   = shift_reg;
        pos_next     = pos_reg;
        sel_idx_next = sel_idx_reg;
        sel_rec_next = sel_rec_reg;
        j_next       = j_reg;
        lk_gw_next   = lk_gw_reg;
        lk_port_next = lk_port_reg;
        status_next  = status_reg;
        hit_next     = hit_reg;
        ogw_next     = ogw_reg;
        oport_next   = oport_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = e;
        rec          = sel_rec_reg;
        start_shift  = 1'b0;
        drop         = 1'b0;

        if (cmd.load) begin
            req_next    = s_req_type;
            addr_next   = s_addr;
            mask_next   = s_mask;
            gw_next     = s_next_hop;
            port_next   = s_port_index;
            st_next     = s_static_flag;
            rd_idx_next = '0;
            pend_next   = 1'b0;
            found_next  = 1'b0;
            shift_next  = 1'b0;
            j_next      = '0;
        end else if (cmd.scan) begin
            // streaming read: entry pidx_reg is on the RAM output this cycle
            if (rd_idx_reg < count_reg) begin
                rd_idx_next = rd_idx_reg + 1'b1;
                pidx_next   = rd_idx_reg;
                pend_next   = 1'b1;
            end else begin
                pend_next   = 1'b0;
            end
            if (pend_reg) begin
                case (req_reg) inside
                    REQ_INSERT, REQ_MERGE: begin
                        if (port_ok) begin
                            // equal keys never compare greater, so any match comes first
                            start_shift = room && !found_reg && !shift_reg && greater;
                            if (shift_reg || start_shift) begin
                                we    = 1'b1;
                                waddr = IDX_W'(pidx_reg + 1'b1);
                            end
                            if (start_shift) begin
                                shift_next = 1'b1;
                                pos_next   = pidx_reg;
                            end else if (!shift_reg) begin
                                if ((req_reg == REQ_INSERT && repl_m && !found_reg) ||
                                    (req_reg == REQ_MERGE && keymatch)) begin
                                    found_next   = 1'b1;
                                    sel_idx_next = pidx_reg;
                                    sel_rec_next = e;
                                end
                            end
                        end
                    end
                    REQ_DELETE, REQ_PURGE, REQ_PURGE_ALL: begin
                        // in-place compaction toward j_reg
                        case (req_reg) inside
                            REQ_DELETE: drop = del_m && !found_reg;
                            REQ_PURGE:  drop = (e.stat == st_reg);
                            default:    drop = 1'b1;
                        endcase
                        if (req_reg == REQ_DELETE && drop) begin
                            found_next = 1'b1;
                        end
                        if (!drop) begin
                            we     = 1'b1;
                            waddr  = j_reg[IDX_W-1:0];
                            j_next = j_reg + 1'b1;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (lk_m && !found_reg) begin
                            found_next   = 1'b1;
                            lk_gw_next   = e.gw[0];
                            lk_port_next = e.port[0];
                        end
                    end
                    default: ;
                endcase
            end
        end else if (cmd.finish) begin
            status_next = STAT_OK;
            hit_next    = 1'b0;
            ogw_next    = '0;
            oport_next  = '0;
            case (req_reg) inside
                REQ_INSERT, REQ_MERGE: begin
                    if (!port_ok) begin
                        status_next = STAT_NOT_FOUND;
                    end else if (found_reg) begin
                        if (req_reg == REQ_INSERT) begin
                            rec.pcount  = PC_W'(1);
                            rec.gw[0]   = gw_reg;
                            rec.port[0] = port_reg;
                            we          = 1'b1;
                        end else if (sel_rec_reg.pcount >= PC_W'(MAX_PATHS)) begin
                            status_next = STAT_PATH_FULL;
                        end else begin
                            rec.gw[sel_rec_reg.pcount[PI_W-1:0]]   = gw_reg;
                            rec.port[sel_rec_reg.pcount[PI_W-1:0]] = port_reg;
                            rec.pcount = PC_W'(sel_rec_reg.pcount + 1'b1);
                            we         = 1'b1;
                        end
                        waddr = sel_idx_reg[IDX_W-1:0];
                        wdata = rec;
                    end else if (!room) begin
                        status_next = STAT_TABLE_FULL;
                    end else begin
                        rec         = '0;
                        rec.prefix  = addr_reg;
                        rec.mask    = mask_reg;
                        rec.stat    = st_reg;
                        rec.pcount  = PC_W'(1);
                        rec.gw[0]   = gw_reg;
                        rec.port[0] = port_reg;
                        we          = 1'b1;
                        waddr       = shift_reg ? pos_reg[IDX_W-1:0]
                                                : count_reg[IDX_W-1:0];
                        wdata       = rec;
                        count_next  = count_reg + 1'b1;
                    end
                end
                REQ_DELETE: begin
                    status_next = found_reg ? STAT_OK : STAT_NOT_FOUND;
                    count_next  = j_reg;
                end
                REQ_PURGE, REQ_PURGE_ALL: begin
                    count_next = j_reg;
                end
                REQ_LOOKUP: begin
                    if (found_reg) begin
                        hit_next   = 1'b1;
                        ogw_next   = (lk_gw_reg != 32'd0) ? lk_gw_reg : addr_reg;
                        oport_next = lk_port_reg;
                    end else begin
                        status_next = STAT_NOT_FOUND;
                        ogw_next    = addr_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_status      = status_reg;
    assign m_hit         = hit_reg;
    assign m_out_gateway = ogw_reg;
    assign m_out_port    = oport_reg;

endmodule

// ===== hdl/prefix_route_table.sv =====
// Top level of the longest-prefix-match route table.
// Depends on prt_pkg, prt_ctrl and prt_datapath.
//
// Input channel s_*: one request item (insert, merge, delete, purge by type,
// lookup, purge all). Result channel m_*: exactly one result item per request.
// Routes live in one RAM row each, kept sorted by mask then masked prefix.
// Every request streams the stored routes once through the RAM read port,
// one route per cycle, while deletes and purges compact in place and new
// routes shift later rows up by one through the write port.
// An item goes from accept through the scan and done states to result valid.
// s_ready returns in the cycle the result goes valid, so a new item is only
// taken once the previous one has reached its result hand-off.
// Reset empties the table (route count to zero), clears m_valid and returns
// to idle with s_ready high; no clearing pass is run.
// When the receiver stalls, the result waits in the output register; a
// following item is still accepted and scanned, and holds before its own
// result hand-off until the register frees up.
module prefix_route_table
    import prt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_addr,
    input  logic [31:0] s_mask,
    input  logic [31:0] s_next_hop,
    input  logic [3:0]  s_port_index,
    input  logic        s_static_flag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_hit,
    output logic [31:0] m_out_gateway,
    output logic [3:0]  m_out_port
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    prt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    prt_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_addr        (s_addr),
        .s_mask        (s_mask),
        .s_next_hop    (s_next_hop),
        .s_port_index  (s_port_index),
        .s_static_flag (s_static_flag),
        .m_status      (m_status),
        .m_hit         (m_hit),
        .m_out_gateway (m_out_gateway),
        .m_out_port    (m_out_port)
    );

endmodule

// ===== hdl/prt_checker.sv =====
// Port-level checks for prefix_route_table, bound to the top level.
// Depends on prt_pkg.
module prt_checker
    import prt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_hit,
    input logic [31:0] m_out_gateway,
    input logic [3:0]  m_out_port
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_hit) &&
            $stable(m_out_gateway) && $stable(m_out_port))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_status == STAT_OK)
        else $error("hit with error status");

    a_miss_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_out_port == 4'd0)
        else $error("port set without hit");

endmodule

bind prefix_route_table prt_checker u_prt_checker (.*);
